// ===== rtl/sparse_polynomial_mult_add_unit_defines.svh =====
// -----------------------------------------------------------------------------
// Sparse polynomial multiply/add unit: assertion macros
// Shared assertion forms, clocked on clk and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_MULT_ADD_UNIT_DEFINES_SVH
`define SPARSE_POLYNOMIAL_MULT_ADD_UNIT_DEFINES_SVH

// same-cycle implication
`define SPMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spma_pkg.sv =====
// -----------------------------------------------------------------------------
// spma_pkg
// Shared constants, function codes and sequencer states.
// -----------------------------------------------------------------------------
package spma_pkg;

  localparam int MaxTermsDef = 64;
  localparam int FuncW       = 3;
  localparam int InCoefW     = 16;
  localparam int InExpW      = 16;
  localparam int CoefW       = 48;
  localparam int ExpW        = 17;
  localparam int TermW       = InCoefW + InExpW;
  localparam int ResW        = CoefW + ExpW;

  typedef enum logic [FuncW-1:0] {
    FN_CLEAR      = 3'd0,
    FN_APPEND1    = 3'd1,
    FN_APPEND2    = 3'd2,
    FN_COMPUTE    = 3'd3,
    FN_FETCH_PROD = 3'd4,
    FN_FETCH_SUM  = 3'd5
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_ROW_LD,
    ST_P_RD,
    ST_P_MUL,
    ST_P_MRG,
    ST_S_RD,
    ST_S_MRG,
    ST_F_RD
  } state_t;

endpackage

// ===== rtl/sparse_polynomial_mult_add_unit.sv =====
// Clear and append finish without leaving idle; a fetch's result strobe is registered.
// Compute: each first-operand row has a row load, then each merged product term a RAM read,
// 16x16 multiply and shared add/compare, then each merged sum term a read and a merge.
// busy is high while compute or fetch runs; results cannot be stalled by the receiver.
// Reset clears counts, read positions and overflow; term stores need no clearing pass.
// -----------------------------------------------------------------------------
// sparse_polynomial_mult_add_unit
// Sparse polynomial product and sum with term-by-term load and read-out.
// -----------------------------------------------------------------------------
module sparse_polynomial_mult_add_unit #(
  parameter int MaxTerms = spma_pkg::MaxTermsDef
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [spma_pkg::FuncW-1:0]           in_func,
  input  logic signed [spma_pkg::InCoefW-1:0]  in_coef_in,
  input  logic [spma_pkg::InExpW-1:0]          in_expon_in,
  output logic                                 out_valid,
  output logic signed [spma_pkg::CoefW-1:0]    out_coef_out,
  output logic [spma_pkg::ExpW-1:0]            out_expon_out,
  output logic                                 out_last_term,
  output logic                                 out_zero_poly,
  output logic                                 out_overflow
);

  localparam int TAW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int PD  = MaxTerms * MaxTerms;
  localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
  localparam int SD  = 2 * MaxTerms;
  localparam int SAW = $clog2(SD);

  logic                        t1_we, t2_we, p_we, p_bank, s_we;
  logic [TAW-1:0]              t_waddr, t1_raddr, t2_raddr;
  logic [spma_pkg::TermW-1:0]  t_wdata, t1_rdata, t2_rdata;
  logic [PAW-1:0]              p_waddr, p_raddr;
  logic [spma_pkg::ResW-1:0]   p0_rdata, p1_rdata, p_rdata, s_rdata, r_wdata;
  logic [SAW-1:0]              s_waddr, s_raddr;

  spma_engine #(.MaxTerms(MaxTerms), .TAW(TAW), .PAW(PAW), .SAW(SAW)) u_engine (
    .clk, .rst_n, .start, .busy,
    .func(in_func), .coef_in(in_coef_in), .expon_in(in_expon_in),
    .out_valid, .coef_out(out_coef_out), .expon_out(out_expon_out),
    .last_term(out_last_term), .zero_poly(out_zero_poly), .overflow(out_overflow),
    .t1_we, .t2_we, .t_waddr, .t_wdata, .t1_raddr, .t2_raddr, .t1_rdata, .t2_rdata,
    .p_we, .p_bank, .p_waddr, .p_raddr, .p_rdata,
    .s_we, .s_waddr, .s_raddr, .s_rdata, .r_wdata
  );

  spma_ram #(.Width(spma_pkg::TermW), .Depth(MaxTerms), .AddrW(TAW)) u_first (
    .clk, .we(t1_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t1_raddr), .rdata(t1_rdata)
  );

  spma_ram #(.Width(spma_pkg::TermW), .Depth(MaxTerms), .AddrW(TAW)) u_second (
    .clk, .we(t2_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t2_raddr), .rdata(t2_rdata)
  );

  // ping-pong product banks: read the live bank, write the other
  spma_ram #(.Width(spma_pkg::ResW), .Depth(PD), .AddrW(PAW)) u_prod0 (
    .clk, .we(p_we && p_bank), .waddr(p_waddr), .wdata(r_wdata),
    .raddr(p_raddr), .rdata(p0_rdata)
  );

  spma_ram #(.Width(spma_pkg::ResW), .Depth(PD), .AddrW(PAW)) u_prod1 (
    .clk, .we(p_we && !p_bank), .waddr(p_waddr), .wdata(r_wdata),
    .raddr(p_raddr), .rdata(p1_rdata)
  );

  assign p_rdata = p_bank ? p1_rdata : p0_rdata;

  spma_ram #(.Width(spma_pkg::ResW), .Depth(SD), .AddrW(SAW)) u_sum (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(r_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );

endmodule

// ===== rtl/spma_ram.sv =====
// -----------------------------------------------------------------------------
// spma_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// -----------------------------------------------------------------------------
module spma_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/spma_engine.sv =====
// -----------------------------------------------------------------------------
// spma_engine
// Command decode, term loading, and the sequencer that runs the product
// row merges and the sum merge through one multiplier and one shared adder.
// -----------------------------------------------------------------------------
`include "sparse_polynomial_mult_add_unit_defines.svh"

module spma_engine #(
  parameter int MaxTerms = spma_pkg::MaxTermsDef,
  parameter int TAW      = 6,
  parameter int PAW      = 12,
  parameter int SAW      = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [spma_pkg::FuncW-1:0]        func,
  input  logic signed [spma_pkg::InCoefW-1:0] coef_in,
  input  logic [spma_pkg::InExpW-1:0]       expon_in,
  output logic                              out_valid,
  output logic signed [spma_pkg::CoefW-1:0] coef_out,
  output logic [spma_pkg::ExpW-1:0]         expon_out,
  output logic                              last_term,
  output logic                              zero_poly,
  output logic                              overflow,
  // operand stores
  output logic                              t1_we,
  output logic                              t2_we,
  output logic [TAW-1:0]                    t_waddr,
  output logic [spma_pkg::TermW-1:0]        t_wdata,
  output logic [TAW-1:0]                    t1_raddr,
  output logic [TAW-1:0]                    t2_raddr,
  input  logic [spma_pkg::TermW-1:0]        t1_rdata,
  input  logic [spma_pkg::TermW-1:0]        t2_rdata,
  // product banks
  output logic                              p_we,
  output logic                              p_bank,
  output logic [PAW-1:0]                    p_waddr,
  output logic [PAW-1:0]                    p_raddr,
  input  logic [spma_pkg::ResW-1:0]         p_rdata,
  // sum store
  output logic                              s_we,
  output logic [SAW-1:0]                    s_waddr,
  output logic [SAW-1:0]                    s_raddr,
  input  logic [spma_pkg::ResW-1:0]         s_rdata,
  output logic [spma_pkg::ResW-1:0]         r_wdata
);

  localparam int TCW = $clog2(MaxTerms + 1);
  localparam int PD  = MaxTerms * MaxTerms;
  localparam int PCW = $clog2(PD + 1);
  localparam int SD  = 2 * MaxTerms;
  localparam int SCW = $clog2(SD + 1);
  localparam int CW  = spma_pkg::CoefW;
  localparam int EW  = spma_pkg::ExpW;
  localparam int ICW = spma_pkg::InCoefW;
  localparam int IEW = spma_pkg::InExpW;

  spma_pkg::state_t state_r, state_nxt;

  logic [TCW-1:0] fcnt_r, fcnt_nxt, scnt_r, scnt_nxt;
  logic [IEW-1:0] flast_r, flast_nxt, slast_r, slast_nxt;
  logic           ovf_r, ovf_nxt;
  logic [PCW-1:0] pcnt_r, pcnt_nxt, ppos_r, ppos_nxt;
  logic [SCW-1:0] sumcnt_r, sumcnt_nxt, spos_r, spos_nxt;
  logic           bank_r, bank_nxt;
  logic [TCW-1:0] k_r, k_nxt, j_r, j_nxt, si_r, si_nxt;
  logic [PCW-1:0] pi_r, pi_nxt, pn_r, pn_nxt;
  logic [SCW-1:0] sn_r, sn_nxt;
  logic           fkind_r, fkind_nxt;
  logic signed [ICW-1:0]  c1_r, c1_nxt;
  logic [IEW-1:0]         e1_r, e1_nxt;
  logic signed [2*ICW-1:0] mul_r, mul_nxt;
  logic [EW-1:0]          re_r, re_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [CW-1:0]   out_coef_r, out_coef_nxt;
  logic [EW-1:0]          out_exp_r, out_exp_nxt;
  logic                   out_last_r, out_last_nxt, out_zero_r, out_zero_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic                 accept;
  logic                 p_avail, j_avail, f_avail;
  logic [EW-1:0]        p_e;
  logic signed [CW-1:0] p_c, s_c;
  logic [EW-1:0]        s_e;
  logic signed [ICW-1:0] f_c, sc_c;
  logic [IEW-1:0]       f_e, sc_e;
  logic                 take_p, p_eq, take_f, take_s;
  logic [PCW-1:0]       pi_inc, pi_step, pn_inc, ppos_inc;
  logic [TCW-1:0]       j_inc, si_inc, k_inc, j_pstep, j_sstep, si_step;
  logic [SCW-1:0]       sn_inc, spos_inc;
  logic                 p_done, s_done, keep;
  logic signed [CW-1:0] add_a, add_b, add_y;
  logic [EW-1:0]        m_e;

  assign accept = start && (state_r == spma_pkg::ST_IDLE);
  assign busy   = (state_r != spma_pkg::ST_IDLE);

  // merge decisions and the shared adder
  always_comb begin
    p_avail  = pi_r < pcnt_r;
    j_avail  = j_r < scnt_r;
    f_avail  = si_r < fcnt_r;
    p_e      = p_rdata[CW+EW-1:CW];
    p_c      = p_rdata[CW-1:0];
    s_e      = s_rdata[CW+EW-1:CW];
    s_c      = s_rdata[CW-1:0];
    f_c      = t1_rdata[ICW+IEW-1:IEW];
    f_e      = t1_rdata[IEW-1:0];
    sc_c     = t2_rdata[ICW+IEW-1:IEW];
    sc_e     = t2_rdata[IEW-1:0];
    take_p   = !j_avail || (p_avail && (p_e > re_r));
    p_eq     = p_avail && (p_e == re_r);
    take_f   = !j_avail || (f_avail && (f_e > sc_e));
    take_s   = !take_f && (!f_avail || (f_e < sc_e));
    pi_inc   = pi_r + PCW'(1);
    pn_inc   = pn_r + PCW'(1);
    ppos_inc = ppos_r + PCW'(1);
    j_inc    = j_r + TCW'(1);
    si_inc   = si_r + TCW'(1);
    k_inc    = k_r + TCW'(1);
    sn_inc   = sn_r + SCW'(1);
    spos_inc = spos_r + SCW'(1);
    pi_step  = (take_p || p_eq) ? pi_inc : pi_r;
    j_pstep  = take_p ? j_r : j_inc;
    si_step  = take_s ? si_r : si_inc;
    j_sstep  = take_f ? j_r : j_inc;
    p_done   = (pi_step >= pcnt_r) && (j_pstep >= scnt_r);
    s_done   = (si_step >= fcnt_r) && (j_sstep >= scnt_r);
    if (state_r == spma_pkg::ST_S_MRG) begin
      add_a = take_s ? {{(CW-ICW){sc_c[ICW-1]}}, sc_c} : {{(CW-ICW){f_c[ICW-1]}}, f_c};
      add_b = (!take_f && !take_s) ? {{(CW-ICW){sc_c[ICW-1]}}, sc_c} : '0;
      m_e   = take_s ? {1'b0, sc_e} : {1'b0, f_e};
    end else begin
      add_a = take_p ? p_c : {{(CW-2*ICW){mul_r[2*ICW-1]}}, mul_r};
      add_b = (!take_p && p_eq) ? p_c : '0;
      m_e   = take_p ? p_e : re_r;
    end
    add_y = add_a + add_b;
    keep  = (add_y != '0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spma_pkg::ST_IDLE: begin
        if (accept) begin
          if (func == spma_pkg::FN_COMPUTE) begin
            if (fcnt_r != '0 && scnt_r != '0) begin
              state_nxt = spma_pkg::ST_ROW;
            end else if (fcnt_r != '0 || scnt_r != '0) begin
              state_nxt = spma_pkg::ST_S_RD;
            end
          end else if (func == spma_pkg::FN_FETCH_PROD || func == spma_pkg::FN_FETCH_SUM) begin
            state_nxt = spma_pkg::ST_F_RD;
          end
        end
      end
      spma_pkg::ST_ROW:    state_nxt = spma_pkg::ST_ROW_LD;
      spma_pkg::ST_ROW_LD: state_nxt = spma_pkg::ST_P_RD;
      spma_pkg::ST_P_RD:   state_nxt = spma_pkg::ST_P_MUL;
      spma_pkg::ST_P_MUL:  state_nxt = spma_pkg::ST_P_MRG;
      spma_pkg::ST_P_MRG: begin
        if (!p_done) begin
          state_nxt = spma_pkg::ST_P_RD;
        end else if (k_inc < fcnt_r) begin
          state_nxt = spma_pkg::ST_ROW;
        end else begin
          state_nxt = spma_pkg::ST_S_RD;
        end
      end
      spma_pkg::ST_S_RD:  state_nxt = spma_pkg::ST_S_MRG;
      spma_pkg::ST_S_MRG: state_nxt = s_done ? spma_pkg::ST_IDLE : spma_pkg::ST_S_RD;
      spma_pkg::ST_F_RD:  state_nxt = spma_pkg::ST_IDLE;
      default:            state_nxt = spma_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    fcnt_nxt = fcnt_r;   scnt_nxt = scnt_r;
    flast_nxt = flast_r; slast_nxt = slast_r;
    ovf_nxt = ovf_r;
    pcnt_nxt = pcnt_r;   ppos_nxt = ppos_r;
    sumcnt_nxt = sumcnt_r; spos_nxt = spos_r;
    bank_nxt = bank_r;
    k_nxt = k_r; j_nxt = j_r; si_nxt = si_r;
    pi_nxt = pi_r; pn_nxt = pn_r; sn_nxt = sn_r;
    fkind_nxt = fkind_r;
    c1_nxt = c1_r; e1_nxt = e1_r;
    mul_nxt = mul_r; re_nxt = re_r;
    out_valid_nxt = 1'b0;
    out_coef_nxt = out_coef_r; out_exp_nxt = out_exp_r;
    out_last_nxt = out_last_r; out_zero_nxt = out_zero_r; out_ovf_nxt = out_ovf_r;
    t1_we = 1'b0;
    t2_we = 1'b0;
    p_we  = 1'b0;
    s_we  = 1'b0;
    case (state_r)
      spma_pkg::ST_IDLE: begin
        if (accept) begin
          case (func)
            spma_pkg::FN_CLEAR: begin
              fcnt_nxt = '0; scnt_nxt = '0; pcnt_nxt = '0; ppos_nxt = '0;
              sumcnt_nxt = '0; spos_nxt = '0; ovf_nxt = 1'b0;
            end
            spma_pkg::FN_APPEND1: begin
              if (coef_in != '0) begin
                if (fcnt_r >= TCW'(MaxTerms)) begin
                  ovf_nxt = 1'b1;
                end else if (fcnt_r == '0 || flast_r > expon_in) begin
                  t1_we = 1'b1;
                  fcnt_nxt = fcnt_r + TCW'(1);
                  flast_nxt = expon_in;
                end
              end
            end
            spma_pkg::FN_APPEND2: begin
              if (coef_in != '0) begin
                if (scnt_r >= TCW'(MaxTerms)) begin
                  ovf_nxt = 1'b1;
                end else if (scnt_r == '0 || slast_r > expon_in) begin
                  t2_we = 1'b1;
                  scnt_nxt = scnt_r + TCW'(1);
                  slast_nxt = expon_in;
                end
              end
            end
            spma_pkg::FN_COMPUTE: begin
              pcnt_nxt = '0; ppos_nxt = '0; spos_nxt = '0;
              k_nxt = '0; si_nxt = '0; j_nxt = '0; sn_nxt = '0;
              if (fcnt_r == '0 && scnt_r == '0) begin
                sumcnt_nxt = '0;
              end
            end
            spma_pkg::FN_FETCH_PROD: fkind_nxt = 1'b0;
            spma_pkg::FN_FETCH_SUM:  fkind_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      spma_pkg::ST_ROW_LD: begin
        c1_nxt = f_c;
        e1_nxt = f_e;
        pi_nxt = '0;
        j_nxt  = '0;
        pn_nxt = '0;
      end
      spma_pkg::ST_P_MUL: begin
        mul_nxt = c1_r * sc_c;
        re_nxt  = {1'b0, e1_r} + {1'b0, sc_e};
      end
      spma_pkg::ST_P_MRG: begin
        if (keep && pn_r < PCW'(PD)) begin
          p_we   = 1'b1;
          pn_nxt = pn_inc;
        end
        pi_nxt = pi_step;
        j_nxt  = j_pstep;
        if (p_done) begin
          pcnt_nxt = (keep && pn_r < PCW'(PD)) ? pn_inc : pn_r;
          bank_nxt = !bank_r;
          k_nxt    = k_inc;
          if (k_inc >= fcnt_r) begin
            si_nxt = '0;
            j_nxt  = '0;
            sn_nxt = '0;
          end
        end
      end
      spma_pkg::ST_S_MRG: begin
        if (keep && sn_r < SCW'(SD)) begin
          s_we   = 1'b1;
          sn_nxt = sn_inc;
        end
        si_nxt = si_step;
        j_nxt  = j_sstep;
        if (s_done) begin
          sumcnt_nxt = (keep && sn_r < SCW'(SD)) ? sn_inc : sn_r;
        end
      end
      spma_pkg::ST_F_RD: begin
        out_valid_nxt = 1'b1;
        out_ovf_nxt   = ovf_r;
        if (!fkind_r) begin
          if (pcnt_r == '0) begin
            out_coef_nxt = '0; out_exp_nxt = '0; out_last_nxt = 1'b1; out_zero_nxt = 1'b1;
          end else begin
            out_coef_nxt = p_c;
            out_exp_nxt  = p_e;
            out_last_nxt = (ppos_inc == pcnt_r);
            out_zero_nxt = 1'b0;
            ppos_nxt     = (ppos_inc == pcnt_r) ? '0 : ppos_inc;
          end
        end else begin
          if (sumcnt_r == '0) begin
            out_coef_nxt = '0; out_exp_nxt = '0; out_last_nxt = 1'b1; out_zero_nxt = 1'b1;
          end else begin
            out_coef_nxt = s_c;
            out_exp_nxt  = s_e;
            out_last_nxt = (spos_inc == sumcnt_r);
            out_zero_nxt = 1'b0;
            spos_nxt     = (spos_inc == sumcnt_r) ? '0 : spos_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spma_pkg::ST_IDLE;
      fcnt_r      <= '0;
      scnt_r      <= '0;
      ovf_r       <= 1'b0;
      pcnt_r      <= '0;
      ppos_r      <= '0;
      sumcnt_r    <= '0;
      spos_r      <= '0;
      bank_r      <= 1'b0;
      k_r         <= '0;
      j_r         <= '0;
      si_r        <= '0;
      pi_r        <= '0;
      pn_r        <= '0;
      sn_r        <= '0;
      fkind_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fcnt_r      <= fcnt_nxt;
      scnt_r      <= scnt_nxt;
      ovf_r       <= ovf_nxt;
      pcnt_r      <= pcnt_nxt;
      ppos_r      <= ppos_nxt;
      sumcnt_r    <= sumcnt_nxt;
      spos_r      <= spos_nxt;
      bank_r      <= bank_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      si_r        <= si_nxt;
      pi_r        <= pi_nxt;
      pn_r        <= pn_nxt;
      sn_r        <= sn_nxt;
      fkind_r     <= fkind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flast_r    <= flast_nxt;
    slast_r    <= slast_nxt;
    c1_r       <= c1_nxt;
    e1_r       <= e1_nxt;
    mul_r      <= mul_nxt;
    re_r       <= re_nxt;
    out_coef_r <= out_coef_nxt;
    out_exp_r  <= out_exp_nxt;
    out_last_r <= out_last_nxt;
    out_zero_r <= out_zero_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid = out_valid_r;
  assign coef_out  = out_coef_r;
  assign expon_out = out_exp_r;
  assign last_term = out_last_r;
  assign zero_poly = out_zero_r;
  assign overflow  = out_ovf_r;

  // memory ports
  assign t_waddr  = (func == spma_pkg::FN_APPEND1) ? fcnt_r[TAW-1:0] : scnt_r[TAW-1:0];
  assign t_wdata  = {coef_in, expon_in};
  assign t1_raddr = (state_r == spma_pkg::ST_ROW || state_r == spma_pkg::ST_ROW_LD) ?
                    k_r[TAW-1:0] : si_r[TAW-1:0];
  assign t2_raddr = j_r[TAW-1:0];
  assign p_bank   = bank_r;
  assign p_waddr  = pn_r[PAW-1:0];
  assign p_raddr  = (state_r == spma_pkg::ST_IDLE) ? ppos_r[PAW-1:0] : pi_r[PAW-1:0];
  assign s_waddr  = sn_r[SAW-1:0];
  assign s_raddr  = spos_r[SAW-1:0];
  assign r_wdata  = {m_e, add_y};

  `SPMA_ASSERT_IMP(a_strobe_idle, out_valid_r, state_r == spma_pkg::ST_IDLE, "strobe while busy")
  `SPMA_ASSERT_NXT(a_fetch_strobe, state_r == spma_pkg::ST_F_RD, out_valid_r, "fetch lost")
  `SPMA_ASSERT_IMP(a_zero_last, out_valid_r && out_zero_r, out_last_r, "empty not last")
  `SPMA_ASSERT_IMP(a_prod_room, p_we, pn_r < PCW'(PD), "product write past end")

endmodule
